[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers for the find/replace RTL; define ASSERT_OFF
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFR_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SFR_ASSERT(lbl, prop, msg)
`define SFR_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[hw/rtl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stream find/replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;

    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    // one output beat as held in the output chain
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } beat_t;

    localparam beat_t BEAT_IDLE = '{valid: 1'b0, data: 8'h00, last: 1'b0};

    typedef struct packed {
        logic upd;      // item accepted, cell takes its next value
        logic shift;    // window slides by one towards the oldest cell
        logic sel;      // incoming byte lands in this cell
        logic active;   // cell lies inside the current pattern length
    } win_ctl_t;

    typedef struct packed {
        logic load;     // new burst loaded into the chain
        logic advance;  // head beat taken, chain moves up by one
    } out_ctl_t;

endpackage

[hw/rtl/stream_find_replace.sv]
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming search and replace of a byte pattern, line by line.
// ----------------------------------------------------------------------------
// Input beats (data_byte, end_of_input) enter on in_valid/in_stall, result
// beats (out_byte, last_of_run) leave on out_valid/out_stall. last_of_run
// marks the final result caused by one input beat; an input beat may cause
// none (window still filling, or match with empty replacement).
// The four registers are written on cfg_write with cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// Pending bytes sit in a row of window cells that compare against the
// pattern in parallel. The results of one input beat are loaded as a burst
// into a chain of output cells, the head of which drives the output port.
// Latency: first result is valid the cycle after the input is accepted.
// Flow: an input beat is taken once the output chain is empty or is
// handing over its final beat, so a beat with results holds off the
// input until the output chain has drained them.
// Reset clears the window fill, the output chain and the registers (pattern
// length resets to one). A stall on the output freezes the chain and holds
// off the input for as long as any result beat is still waiting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_input,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   last_of_run
);

    localparam int PAT_CAP = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
    localparam int REP_CAP = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;
    localparam int BURST   = (PAT_CAP > REP_CAP) ? PAT_CAP : REP_CAP;
    localparam int CNT_W   = $clog2(PAT_CAP + 1);
    localparam int BC_W    = $clog2(BURST + 1);

    // configuration registers
    logic [CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [3:0]            pattern_length_reg;
    logic [CFG_DATA_W-1:0] replacement_bytes_reg;
    logic [3:0]            replacement_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= 4'd1;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_data;
                REG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[3:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data;
                REG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[3:0];
            endcase
        end
    end

    logic [CNT_W-1:0] plen;
    logic [BC_W-1:0]  rlen;

    always_comb
    begin
        if (pattern_length_reg == 4'd0)
        begin
            plen = CNT_W'(1);
        end
        else if (pattern_length_reg > 4'(PAT_CAP))
        begin
            plen = CNT_W'(PAT_CAP);
        end
        else
        begin
            plen = pattern_length_reg[CNT_W-1:0];
        end

        if (replacement_length_reg > 4'(REP_CAP))
        begin
            rlen = BC_W'(REP_CAP);
        end
        else
        begin
            rlen = BC_W'(replacement_length_reg);
        end
    end

    // handshake
    beat_t           chain [BURST];
    logic [BURST-1:0] valid_vec;
    logic            take;
    logic            room;
    logic            accept;

    always_comb
    begin
        for (int j = 0; j < BURST; j++)
        begin
            valid_vec[j] = chain[j].valid;
        end
    end

    assign out_valid   = chain[0].valid;
    assign out_byte    = chain[0].data;
    assign last_of_run = chain[0].last;
    assign take        = out_valid && !out_stall;
    assign room        = ((valid_vec >> 1) == '0) && (!valid_vec[0] || take);
    assign in_stall    = !room;
    assign accept      = in_valid && room;

    // window cells
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] fill_inc;
    logic             shift;
    logic [7:0]       win_cur [PAT_CAP];
    logic [PAT_CAP-1:0] eq_vec;

    for (genvar k = 0; k < PAT_CAP; k++)
    begin : g_win
        win_ctl_t   wctl;
        logic [7:0] nb;

        assign wctl = '{upd:    accept,
                        shift:  shift,
                        sel:    (fill_reg == CNT_W'(k)),
                        active: (CNT_W'(k) < plen)};

        if (k == PAT_CAP - 1)
        begin : g_end
            assign nb = win_cur[k];
        end
        else
        begin : g_mid
            assign nb = win_cur[k+1];
        end

        sfr_win_cell u_cell (
            .clk      (clk),
            .ctl      (wctl),
            .in_byte  (data_byte),
            .nb_byte  (nb),
            .pat_byte (pattern_bytes_reg[8*k +: 8]),
            .cur_byte (win_cur[k]),
            .eq       (eq_vec[k])
        );
    end

    // decide what this beat emits and what the window keeps
    logic            flush_all;
    logic            full;
    logic            match;
    logic            src_rep;
    logic [BC_W-1:0] burst_len;

    assign fill_inc  = fill_reg + CNT_W'(1);
    assign flush_all = (data_byte == NEWLINE) || (fill_reg >= plen);
    assign full      = (fill_inc == plen);
    assign match     = &eq_vec;

    always_comb
    begin
        src_rep   = 1'b0;
        shift     = 1'b0;
        burst_len = '0;
        fill_next = '0;
        priority if (flush_all)
        begin
            burst_len = BC_W'(fill_inc);
        end
        else if (full && match)
        begin
            src_rep   = 1'b1;
            burst_len = rlen;
        end
        else if (full)
        begin
            // oldest byte out, window slides; end of input flushes the rest
            shift     = 1'b1;
            burst_len = end_of_input ? BC_W'(plen) : BC_W'(1);
            fill_next = end_of_input ? '0 : fill_reg;
        end
        else
        begin
            burst_len = end_of_input ? BC_W'(fill_inc) : '0;
            fill_next = end_of_input ? '0 : fill_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    // output chain
    out_ctl_t octl;

    assign octl = '{load: accept, advance: take};

    for (genvar j = 0; j < BURST; j++)
    begin : g_out
        beat_t      ld;
        beat_t      nb;
        logic [7:0] win_byte;

        if (j < PAT_CAP)
        begin : g_wb
            assign win_byte = win_cur[j];
        end
        else
        begin : g_nowb
            assign win_byte = 8'h00;
        end

        assign ld = '{valid: (BC_W'(j) < burst_len),
                      data:  src_rep ? replacement_bytes_reg[8*j +: 8] : win_byte,
                      last:  (BC_W'(j + 1) == burst_len)};

        if (j == BURST - 1)
        begin : g_tail
            assign nb = BEAT_IDLE;
        end
        else
        begin : g_link
            assign nb = chain[j+1];
        end

        sfr_out_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (octl),
            .load_beat (ld),
            .nb_beat   (nb),
            .beat      (chain[j])
        );
    end

    `SFR_ASSERT_NEVER(a_fill_range, fill_reg >= CNT_W'(PAT_CAP), "window fill out of range")
    `SFR_ASSERT(a_chain_packed, !valid_vec[0] |-> (valid_vec == '0), "hole in output chain")
    `SFR_ASSERT(a_last_is_tail, (valid_vec[0] && chain[0].last) |-> ((valid_vec >> 1) == '0), "beats after last")
    `SFR_ASSERT(a_newline_out, (accept && (data_byte == NEWLINE)) |=> out_valid, "newline lost")

endmodule

[hw/rtl/sfr_win_cell.sv]
// ----------------------------------------------------------------------------
// sfr_win_cell
// One window byte: holds a pending byte, compares it with its pattern byte
// and passes it to the older neighbour when the window slides.
// ----------------------------------------------------------------------------
module sfr_win_cell
    import sfr_pkg::*;
(
    input  logic       clk,
    input  win_ctl_t   ctl,
    input  logic [7:0] in_byte,
    input  logic [7:0] nb_byte,
    input  logic [7:0] pat_byte,
    output logic [7:0] cur_byte,
    output logic       eq
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // view of the window with the incoming byte already in place
    assign cur_byte  = ctl.sel ? in_byte : byte_reg;
    assign eq        = !ctl.active || (cur_byte == pat_byte);
    assign byte_next = ctl.shift ? nb_byte : cur_byte;

    always_ff @(posedge clk)
    begin
        if (ctl.upd)
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

[hw/rtl/sfr_out_cell.sv]
// ----------------------------------------------------------------------------
// sfr_out_cell
// One stage of the output chain: loaded with a burst beat, then moves up
// towards the head each time the head beat is taken.
// ----------------------------------------------------------------------------
module sfr_out_cell
    import sfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  out_ctl_t ctl,
    input  beat_t    load_beat,
    input  beat_t    nb_beat,
    output beat_t    beat
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= load_beat.valid;
        end
        else if (ctl.advance)
        begin
            valid_reg <= nb_beat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            data_reg <= load_beat.data;
            last_reg <= load_beat.last;
        end
        else if (ctl.advance)
        begin
            data_reg <= nb_beat.data;
            last_reg <= nb_beat.last;
        end
    end

    assign beat = '{valid: valid_reg, data: data_reg, last: last_reg};

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stream_find_replace. Byte beats are pushed in with
// random gaps and results drained with random stalls; a scoreboard holds its
// own copy of the window and registers, predicts the rewritten text of each
// accepted beat and checks every result beat against it in order.
// ----------------------------------------------------------------------------
module testbench;
    import sfr_pkg::*;

    class rewrite_tracker;
        typedef struct {
            logic [7:0] text;
            logic       last;
        } text_beat_t;

        text_beat_t  text_due[$];
        logic [7:0]  burst[$];
        logic [7:0]  held[8];
        int          held_count;
        logic [63:0] pat_bytes;
        logic [63:0] rep_bytes;
        logic [3:0]  pat_len_reg;
        logic [3:0]  rep_len_reg;
        int          fails;

        function new();
            held_count  = 0;
            pat_bytes   = '0;
            rep_bytes   = '0;
            pat_len_reg = 4'd1;
            rep_len_reg = 4'd0;
            fails       = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [63:0] val);
            case (idx)
                REG_PATTERN_BYTES:      pat_bytes   = val;
                REG_PATTERN_LENGTH:     pat_len_reg = val[3:0];
                REG_REPLACEMENT_BYTES:  rep_bytes   = val;
                REG_REPLACEMENT_LENGTH: rep_len_reg = val[3:0];
                default: ;
            endcase
        endfunction

        function void release_held();
            int k;
            for (k = 0; k < held_count; k++)
                burst.push_back(held[k]);
            held_count = 0;
        endfunction

        // accepted input beat: work out the bytes it lets out
        function void note_char(logic [7:0] b, logic eoi);
            int         plen;
            int         rlen;
            int         k;
            logic       hit;
            text_beat_t t;
            plen = (pat_len_reg == 0) ? 1 : ((pat_len_reg > 8) ? 8 : int'(pat_len_reg));
            rlen = (rep_len_reg > 8) ? 8 : int'(rep_len_reg);
            burst.delete();
            // newline, or a pattern shortened under a fuller window: pass all through
            if (b == NEWLINE || held_count >= plen)
            begin
                release_held();
                burst.push_back(b);
            end
            else
            begin
                held[held_count] = b;
                held_count++;
                if (held_count == plen)
                begin
                    hit = 1'b1;
                    for (k = 0; k < plen; k++)
                        if (held[k] != pat_bytes[8*k +: 8])
                            hit = 1'b0;
                    if (hit)
                    begin
                        for (k = 0; k < rlen; k++)
                            burst.push_back(rep_bytes[8*k +: 8]);
                        held_count = 0;
                    end
                    else
                    begin
                        burst.push_back(held[0]);
                        for (k = 1; k < held_count; k++)
                            held[k-1] = held[k];
                        held_count--;
                    end
                end
                if (eoi)
                    release_held();
            end
            while (burst.size() > 8)
                void'(burst.pop_back());
            foreach (burst[i])
            begin
                t.text = burst[i];
                t.last = (i == burst.size() - 1);
                text_due.push_back(t);
            end
        endfunction

        function void check_char(logic [7:0] got_text, logic got_last);
            text_beat_t want;
            if (text_due.size() == 0)
            begin
                $error("out_byte: nothing expected, got %02h (last_of_run %0b)",
                       got_text, got_last);
                fails++;
            end
            else
            begin
                want = text_due.pop_front();
                if (got_text !== want.text)
                begin
                    $error("out_byte: expected %02h, got %02h", want.text, got_text);
                    fails++;
                end
                if (got_last !== want.last)
                begin
                    $error("last_of_run: expected %0b, got %0b", want.last, got_last);
                    fails++;
                end
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             data_byte;
    logic                   end_of_input;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             out_byte;
    logic                   last_of_run;

    rewrite_tracker trk;
    int             max_wait = 8;

    stream_find_replace DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            trk.check_char(out_byte, last_of_run);

    // receiver: random stall before each result beat
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = $urandom_range(0, max_wait);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_char(logic [7:0] b, logic eoi);
        int gap;
        gap = $urandom_range(0, max_wait);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_input <= eoi;
        do @(posedge clk); while (in_stall);
        trk.note_char(b, eoi);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        trk.set_reg(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every expected beat, then idle on the clock for beats with no result
    task automatic settle();
        in_valid <= 1'b0;
        while (trk.text_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(int n, int shape);
        logic [63:0] pat;
        logic [3:0]  plen_w;
        logic [3:0]  rlen_w;
        logic        letters;
        int          eff;
        int          r;
        int          k;
        int          cut;
        int          sent;
        logic [7:0]  b;
        letters = ($urandom_range(0, 1) == 1);
        if (letters)
            for (k = 0; k < 8; k++)
                pat[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 1));
        else
            pat = {$urandom, $urandom};
        plen_w = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
        rlen_w = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(0, 8));
        // extremes on the first two phases
        if (shape == 0)
        begin
            pat    = '1;
            plen_w = 4'd8;
            rlen_w = 4'd8;
        end
        else if (shape == 1)
        begin
            pat    = '0;
            plen_w = 4'd1;
            rlen_w = 4'd0;
        end
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_PATTERN_LENGTH, 64'(plen_w));
        write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
        write_reg(REG_REPLACEMENT_LENGTH, 64'(rlen_w));
        eff = (plen_w == 0) ? 1 : ((plen_w > 8) ? 8 : int'(plen_w));
        max_wait = ($urandom_range(0, 3) == 0) ? 0 : 8;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 9);
            if (r <= 4)
            begin
                for (k = 0; k < eff; k++)
                    send_char(pat[8*k +: 8], $urandom_range(0, 15) == 0);
                sent += eff;
            end
            else if (r == 5)
            begin
                // broken occurrence: a prefix and then some other byte
                cut = $urandom_range(1, eff);
                for (k = 0; k < cut; k++)
                    send_char(pat[8*k +: 8], $urandom_range(0, 15) == 0);
                send_char(8'($urandom), $urandom_range(0, 15) == 0);
                sent += cut + 1;
            end
            else if (r == 6)
            begin
                send_char(NEWLINE, $urandom_range(0, 15) == 0);
                sent++;
            end
            else
            begin
                if (letters && $urandom_range(0, 1) == 1)
                    b = 8'h61 + 8'($urandom_range(0, 1));
                else
                    b = 8'($urandom);
                send_char(b, $urandom_range(0, 15) == 0);
                sent++;
            end
        end
        settle();
    endtask

    initial
    begin
        trk          = new();
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_PATTERN_BYTES;
        cfg_data     = '0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        end_of_input = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: single zero byte pattern, matches deleted
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(NEWLINE, 1'b1);
        send_char(8'h00, 1'b0);
        settle();

        // "abc" -> eight bytes (length register saturates)
        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        write_reg(REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h63, 1'b0);
        send_char(8'h78, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h63, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(NEWLINE, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b1);
        settle();

        // zero pattern length acts as one
        write_reg(REG_PATTERN_BYTES, '1);
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
        send_char(8'hFF, 1'b0);
        send_char(8'h7E, 1'b0);
        settle();

        // oversized length saturates; then shorten it with bytes pending
        write_reg(REG_PATTERN_LENGTH, 64'd15);
        write_reg(REG_REPLACEMENT_BYTES, '0);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd1);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b0);
        settle();
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        send_char(8'h41, 1'b0);
        settle();

        for (int p = 0; p < 12; p++)
            random_phase(22, p);

        if (trk.fails == 0 && trk.text_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
